// ===== hdl/lsu_pkg.sv =====
// ----------------------------------------------------------------------------
// lsu_pkg
// Shared types, constants and helpers of the load/store unit.
// ----------------------------------------------------------------------------
package lsu_pkg;

    localparam int DEF_MEM_BYTES = 65536;
    localparam int DATA_W        = 32;
    localparam int LIMIT_W       = 17;
    localparam int MODE_W        = 3;
    localparam int NUM_BANKS     = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

    // access kinds
    localparam logic [MODE_W-1:0] MODE_LB  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LH  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LW  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LBU = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LHU = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SB  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SH  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SW  = 3'd7;

    typedef struct packed {
        logic                 fault;
        logic                 store;
        logic [NUM_BANKS-1:0] en;
    } t_acc_ctl;

    // number of bytes the access touches
    function automatic logic [2:0] access_size(input logic [MODE_W-1:0] mode);
        logic [2:0] size;
        unique case (mode) inside
            MODE_LB, MODE_LBU, MODE_SB: size = 3'd1;
            MODE_LH, MODE_LHU, MODE_SH: size = 3'd2;
            default:                    size = 3'd4;
        endcase
        return size;
    endfunction

    function automatic logic is_store(input logic [MODE_W-1:0] mode);
        return (mode == MODE_SB) || (mode == MODE_SH) || (mode == MODE_SW);
    endfunction

    // sign or zero extension of the raw little-endian word
    function automatic logic [DATA_W-1:0] format_load(input logic [MODE_W-1:0] mode,
                                                      input logic [DATA_W-1:0] raw);
        logic [DATA_W-1:0] res;
        unique case (mode)
            MODE_LB:  res = {{24{raw[7]}}, raw[7:0]};
            MODE_LH:  res = {{16{raw[15]}}, raw[15:0]};
            MODE_LW:  res = raw;
            MODE_LBU: res = {24'd0, raw[7:0]};
            MODE_LHU: res = {16'd0, raw[15:0]};
            default:  res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/lsu_bank.sv =====
// ----------------------------------------------------------------------------
// lsu_bank
// One byte-wide bank of the data memory, one port, registered read.
// ----------------------------------------------------------------------------
module lsu_bank #(
    parameter int ROWS  = lsu_pkg::DEF_MEM_BYTES / lsu_pkg::NUM_BANKS,
    parameter int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [ROW_W-1:0] i_row,
    input  logic [7:0]       i_wdata,
    output logic [7:0]       o_rdata
);

    logic [7:0] r_mem [ROWS];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_row] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_row];
        end
    end

    assign o_rdata = r_q;

endmodule

// ===== hdl/lsu_agu.sv =====
// ----------------------------------------------------------------------------
// lsu_agu
// Address decode: bounds check, bank enables, bank rows and store lanes.
// ----------------------------------------------------------------------------
module lsu_agu #(
    parameter int ROW_W = 14
) (
    input  logic [lsu_pkg::MODE_W-1:0]  i_mode,
    input  logic [lsu_pkg::DATA_W-1:0]  i_address,
    input  logic [lsu_pkg::DATA_W-1:0]  i_store_data,
    input  logic [lsu_pkg::LIMIT_W-1:0] i_limit,
    output lsu_pkg::t_acc_ctl           o_ctl,
    output logic [ROW_W-1:0]            o_row   [lsu_pkg::NUM_BANKS],
    output logic [7:0]                  o_wdata [lsu_pkg::NUM_BANKS]
);

    logic [2:0]                  size;
    logic [lsu_pkg::DATA_W:0]    end_addr;
    logic [1:0]                  lo;
    logic [ROW_W-1:0]            row0;
    logic [1:0]                  lane [lsu_pkg::NUM_BANKS];

    assign size     = lsu_pkg::access_size(i_mode);
    // end computed one bit wider so accesses near the top of the space fault
    assign end_addr = {1'b0, i_address} + 33'(size);
    assign lo       = i_address[1:0];
    assign row0     = ROW_W'(i_address >> 2);

    always_comb begin
        o_ctl.fault = end_addr > 33'(i_limit);
        o_ctl.store = lsu_pkg::is_store(i_mode);
        for (int b = 0; b < lsu_pkg::NUM_BANKS; b++) begin
            lane[b]     = 2'(b) - lo;
            o_ctl.en[b] = 3'(lane[b]) < size;
            // banks below the start byte hold the next row
            o_row[b]    = row0 + ROW_W'(2'(b) < lo);
            o_wdata[b]  = i_store_data[8*lane[b] +: 8];
        end
    end

endmodule

// ===== hdl/load_store_unit.sv =====
// ----------------------------------------------------------------------------
// load_store_unit
// RV32I memory stage: byte loads/stores on a banked little-endian memory.
// ----------------------------------------------------------------------------
// result path: an accepted item goes through the bank read stage (r_s1) and then the output register to o_valid
// throughput: one item per cycle while o_stall is low; the four byte banks each do one access a cycle
// a store writes its banks at acceptance, so a following load sees the new bytes
// reset: the banks are cleared one row a cycle, from row 0 to the last row, input
//   stalled meanwhile; mem_limit returns to 65536 (capped at MEM_BYTES) and can be written at any time
module load_store_unit #(
    parameter int MEM_BYTES = lsu_pkg::DEF_MEM_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [lsu_pkg::MODE_W-1:0]    i_mode,
    input  logic [lsu_pkg::DATA_W-1:0]    i_address,
    input  logic [lsu_pkg::DATA_W-1:0]    i_store_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lsu_pkg::DATA_W-1:0]    o_load_data,
    output logic                          o_access_fault,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [lsu_pkg::LIMIT_W-1:0]   i_mem_limit
);

    localparam int NB       = lsu_pkg::NUM_BANKS;
    localparam int ROWS     = (MEM_BYTES + NB - 1) / NB;
    localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [32:0] CAP = 33'(MEM_BYTES);
    localparam logic [lsu_pkg::LIMIT_W-1:0] LIMIT_INIT =
        (33'(lsu_pkg::LIMIT_RESET) > CAP) ? CAP[lsu_pkg::LIMIT_W-1:0] : lsu_pkg::LIMIT_RESET;

    logic [lsu_pkg::LIMIT_W-1:0] r_limit, n_limit;
    logic                        r_clearing;
    logic [ROW_W-1:0]            r_clr_row;

    logic                        r_s1_valid;
    logic [lsu_pkg::MODE_W-1:0]  r_s1_mode;
    logic                        r_s1_fault;
    logic [1:0]                  r_s1_lo;

    logic                        r_out_valid;
    logic [lsu_pkg::DATA_W-1:0]  r_load_data, n_load_data;
    logic                        r_fault;

    lsu_pkg::t_acc_ctl           ctl;
    logic [ROW_W-1:0]            agu_row   [NB];
    logic [7:0]                  agu_wdata [NB];
    logic [7:0]                  bank_q    [NB];
    logic [lsu_pkg::DATA_W-1:0]  raw;

    logic acc;
    logic s1_move;

    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_clearing || (r_s1_valid && !s1_move);
    assign acc     = i_valid && !o_stall;

    // effective limit is capped at the memory size when written
    assign o_cfg_ready = 1'b1;
    assign n_limit = (33'(i_mem_limit) > CAP) ? CAP[lsu_pkg::LIMIT_W-1:0] : i_mem_limit;

    lsu_agu #(
        .ROW_W (ROW_W)
    ) u_agu (
        .i_mode       (i_mode),
        .i_address    (i_address),
        .i_store_data (i_store_data),
        .i_limit      (r_limit),
        .o_ctl        (ctl),
        .o_row        (agu_row),
        .o_wdata      (agu_wdata)
    );

    for (genvar b = 0; b < NB; b++) begin : g_bank
        logic             we;
        logic [ROW_W-1:0] row;
        logic [7:0]       wd;

        assign we  = r_clearing || (acc && ctl.store && !ctl.fault && ctl.en[b]);
        assign row = r_clearing ? r_clr_row : agu_row[b];
        assign wd  = r_clearing ? 8'd0 : agu_wdata[b];

        lsu_bank #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_re    (acc),
            .i_row   (row),
            .i_wdata (wd),
            .o_rdata (bank_q[b])
        );
    end

    // rotate bank outputs back into byte order
    always_comb begin
        for (int k = 0; k < NB; k++) begin
            raw[8*k +: 8] = bank_q[2'(k) + r_s1_lo];
        end
        if (r_s1_fault || lsu_pkg::is_store(r_s1_mode)) begin
            n_load_data = '0;
        end else begin
            n_load_data = lsu_pkg::format_load(r_s1_mode, raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= LIMIT_INIT;
            r_clearing  <= 1'b1;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= n_limit;
            end
            if (r_clearing) begin
                r_clr_row <= r_clr_row + ROW_W'(1);
                if (r_clr_row == ROW_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_mode  <= i_mode;
            r_s1_fault <= ctl.fault;
            r_s1_lo    <= i_address[1:0];
        end
        if (s1_move) begin
            r_load_data <= n_load_data;
            r_fault     <= r_s1_fault;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_load_data    = r_load_data;
    assign o_access_fault = r_fault;

    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_valid)
        else $error("accepted item did not reach the read stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_move |=> r_s1_valid && $stable(r_s1_mode) && $stable(r_s1_lo))
        else $error("blocked read stage lost its item");

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_fault |-> r_load_data == '0)
        else $error("faulting access returned nonzero data");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing && r_clr_row == ROW_LAST |=> !r_clearing)
        else $error("clearing pass did not finish");

endmodule
